### hdl/pip_pkg.sv
// ============================================================================
// pip_pkg
// Shared types and constants of the point-in-polygon test block.
// ============================================================================
package pip_pkg;

    // Request actions carried in the low bits of the input tdata.
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Input and output tdata layout.
    localparam int unsigned ACT_W       = 2;
    localparam int unsigned COORD_IN_W  = 32;
    localparam int unsigned X_LSB       = ACT_W;
    localparam int unsigned Y_LSB       = ACT_W + COORD_IN_W;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned RES_W       = 4;
    localparam int unsigned OUT_TDATA_W = 8;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned TOL_W       = 16;
    localparam logic        REG_EDGE_TOL = 1'b0;

    // Ring rules.
    localparam int unsigned MIN_RING_POINTS = 4;
    localparam int unsigned CLOSE_BACK      = 2;

    // Vertex window: previous, current and next vertex of an edge.
    localparam int unsigned WINDOW = 3;

    typedef struct packed {
        logic shift;
        logic flush;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef struct packed {
        logic valid;
        logic last;
        logic on_edge;
        logic hit;
    } t_edge_res;

endpackage

### hdl/point_in_polygon_test.sv
// ============================================================================
// point_in_polygon_test
// Point-in-polygon test against a stored closed ring of vertices.
//
// Requests clear the ring, append a vertex or query a point; only a query
// gives a result. The ring lives in a RAM and is given with its first vertex
// repeated at the end. A query over a ring of n stored points streams n + 1
// vertices out of the RAM, one a cycle, through a window of three vertex
// cells into a four-stage edge evaluator; a query over fewer than four
// points reads no vertex and reports a short ring. A query holds the block
// until its verdict is in the output register. The next request is taken
// while a result still waits in the output register, but a finished query
// holds the block until the previous result has been taken. Edge tolerance
// is to be written through the configuration port only while the block is
// idle; the block itself does not enforce this.
// ============================================================================
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int unsigned MAX_RING_POINTS = 64,
    parameter int unsigned COORD_WIDTH     = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // action [1:0], coord_x [33:2], coord_y [65:34], zero fill [71:66]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // inside_res [0], on_boundary [1], ring_too_short [2], ring_overflow [3]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned AW = $clog2(MAX_RING_POINTS);
    localparam int unsigned LW = $clog2(MAX_RING_POINTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [LW-1:0]    r_len, n_len;
    logic             r_ovf, n_ovf;
    logic [TOL_W-1:0] r_tol, n_tol;
    logic signed [CW-1:0] r_px, n_px, r_py, n_py;
    logic [LW-1:0]    r_rd_cnt, n_rd_cnt;
    logic             r_rv, n_rv, r_rlast, n_rlast, r_pushed, n_pushed;
    logic             r_onb, n_onb, r_par, n_par, r_short, n_short;
    logic             r_ov, n_ov;
    logic [RES_W-1:0] r_out, n_out;

    logic             w_in_acc, w_cfg_wr, w_app_ok;
    logic [1:0]       w_action;
    logic signed [CW-1:0] w_cx, w_cy;
    logic [LW-1:0]    w_close, w_prev;
    logic [AW-1:0]    w_raddr;
    logic [2*CW-1:0]  w_rdata;
    t_cell_ctl        w_ctl;
    t_tag             w_tag;
    t_edge_res        w_res;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_action = s_axis_tdata[ACT_W-1:0];
    assign w_cx     = s_axis_tdata[X_LSB +: CW];
    assign w_cy     = s_axis_tdata[Y_LSB +: CW];
    assign w_app_ok = r_len < LW'(MAX_RING_POINTS);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign w_close = r_len - LW'(CLOSE_BACK);
    assign w_prev  = r_rd_cnt - LW'(1);
    assign w_raddr = (r_rd_cnt == '0) ? w_close[AW-1:0] : w_prev[AW-1:0];

    pip_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_RING_POINTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (w_action == ACT_APPEND) && w_app_ok),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata ({w_cy, w_cx}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Vertex window; element 0 is the RAM output, element k+1 is cell k.
    logic signed [CW-1:0] w_vx [WINDOW+1];
    logic signed [CW-1:0] w_vy [WINDOW+1];
    logic                 w_vv [WINDOW+1];
    logic                 w_vl [WINDOW+1];

    assign w_ctl.shift = r_rv;
    assign w_ctl.flush = w_in_acc && (w_action == ACT_QUERY);
    assign w_vx[0] = w_rdata[CW-1:0];
    assign w_vy[0] = w_rdata[2*CW-1:CW];
    assign w_vv[0] = 1'b1;
    assign w_vl[0] = r_rlast;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        pip_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_x     (w_vx[k]),
            .i_y     (w_vy[k]),
            .i_v     (w_vv[k]),
            .i_last  (w_vl[k]),
            .o_x     (w_vx[k+1]),
            .o_y     (w_vy[k+1]),
            .o_v     (w_vv[k+1]),
            .o_last  (w_vl[k+1])
        );
    end

    assign w_tag.valid = r_pushed && w_vv[WINDOW];
    assign w_tag.last  = w_vl[1];

    pip_edge #(
        .CW (CW)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_ax    (w_vx[2]),
        .i_ay    (w_vy[2]),
        .i_bx    (w_vx[1]),
        .i_by    (w_vy[1]),
        .i_cx    (w_vx[3]),
        .i_cy    (w_vy[3]),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_tol   (r_tol),
        .o_res   (w_res)
    );

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_tol    = r_tol;
        n_px     = r_px;
        n_py     = r_py;
        n_rd_cnt = r_rd_cnt;
        n_rv     = 1'b0;
        n_rlast  = 1'b0;
        n_pushed = r_rv;
        n_onb    = r_onb;
        n_par    = r_par;
        n_short  = r_short;
        n_ov     = r_ov;
        n_out    = r_out;

        if (w_cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_EDGE_TOL)) begin
            n_tol = pwdata[TOL_W-1:0];
        end

        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        if (w_res.valid) begin
            n_onb = r_onb | w_res.on_edge;
            n_par = r_par ^ w_res.hit;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_action)
                        ACT_CLEAR: begin
                            n_len = '0;
                            n_ovf = 1'b0;
                        end
                        ACT_APPEND: begin
                            if (w_app_ok) begin
                                n_len = r_len + LW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_px     = w_cx;
                            n_py     = w_cy;
                            n_onb    = 1'b0;
                            n_par    = 1'b0;
                            n_rd_cnt = '0;
                            n_short  = r_len < LW'(MIN_RING_POINTS);
                            n_state  = (r_len < LW'(MIN_RING_POINTS)) ? ST_DONE : ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_rv     = 1'b1;
                n_rlast  = r_rd_cnt == r_len;
                n_rd_cnt = r_rd_cnt + LW'(1);
                if (r_rd_cnt == r_len) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_res.valid && w_res.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_out   = {r_ovf, r_short, r_onb, r_onb | r_par};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_tol    <= '0;
            r_rd_cnt <= '0;
            r_rv     <= 1'b0;
            r_rlast  <= 1'b0;
            r_pushed <= 1'b0;
            r_onb    <= 1'b0;
            r_par    <= 1'b0;
            r_short  <= 1'b0;
            r_ov     <= 1'b0;
            r_out    <= '0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_tol    <= n_tol;
            r_rd_cnt <= n_rd_cnt;
            r_rv     <= n_rv;
            r_rlast  <= n_rlast;
            r_pushed <= n_pushed;
            r_onb    <= n_onb;
            r_par    <= n_par;
            r_short  <= n_short;
            r_ov     <= n_ov;
            r_out    <= n_out;
        end
        r_px <= n_px;
        r_py <= n_py;
    end

    assign s_axis_tready = r_state == ST_IDLE;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, r_out};
    assign pready        = 1'b1;
    assign prdata        = (paddr[CFG_ADDR_W-1:2] == REG_EDGE_TOL) ?
                           {{(CFG_DATA_W-TOL_W){1'b0}}, r_tol} : '0;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_RING_POINTS))
        else $error("Ring length beyond capacity.");

    a_res_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == ST_RUN || r_state == ST_WAIT))
        else $error("Edge result outside a query.");

    a_last_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.last) |-> (r_state == ST_WAIT))
        else $error("Last edge result before all reads were issued.");

    a_short_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_short) |-> (!r_onb && !r_par))
        else $error("Short ring query reports inside.");

endmodule

### hdl/pip_ram.sv
// ============================================================================
// pip_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module pip_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pip_cell.sv
// ============================================================================
// pip_cell
// One vertex cell of the edge window; hands its vertex to the next cell.
// ============================================================================
module pip_cell
    import pip_pkg::*;
#(
    parameter int unsigned CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic                 i_v,
    input  logic                 i_last,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic                 o_v,
    output logic                 o_last
);

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic                 r_v;
    logic                 r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ctl.flush) begin
            r_v <= 1'b0;
        end else if (i_ctl.shift) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_last <= i_last;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_v    = r_v;
    assign o_last = r_last;

endmodule

### hdl/pip_edge.sv
// ============================================================================
// pip_edge
// Four-stage edge evaluator: on-edge test and ray crossing test of one edge.
// ============================================================================
module pip_edge
    import pip_pkg::*;
#(
    parameter int unsigned CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tag                 i_tag,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic [TOL_W-1:0]     i_tol,
    output t_edge_res            o_res
);

    localparam int unsigned DW = CW + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned SW = PW + 1;
    localparam int unsigned BW = ((DW > TOL_W) ? DW : TOL_W) + 1;
    localparam int unsigned FW = ((SW > TOL_W) ? SW : TOL_W) + 1;

    // Stage 1: coordinate differences.
    logic signed [DW-1:0] w_ex, w_ey, w_qx, w_qy, w_rx, w_ry, w_wx, w_dy;
    logic                 w_cond;

    assign w_ex = $signed({i_bx[CW-1], i_bx}) - $signed({i_ax[CW-1], i_ax});
    assign w_ey = $signed({i_by[CW-1], i_by}) - $signed({i_ay[CW-1], i_ay});
    assign w_qx = $signed({i_px[CW-1], i_px}) - $signed({i_ax[CW-1], i_ax});
    assign w_qy = $signed({i_py[CW-1], i_py}) - $signed({i_ay[CW-1], i_ay});
    assign w_rx = $signed({i_px[CW-1], i_px}) - $signed({i_bx[CW-1], i_bx});
    assign w_ry = $signed({i_py[CW-1], i_py}) - $signed({i_by[CW-1], i_by});
    assign w_wx = $signed({i_cx[CW-1], i_cx}) - $signed({i_ax[CW-1], i_ax});
    assign w_dy = $signed({i_cy[CW-1], i_cy}) - $signed({i_ay[CW-1], i_ay});
    assign w_cond = (i_ay > i_py) != (i_cy > i_py);

    logic signed [DW-1:0] r1_ex, r1_ey, r1_qx, r1_qy, r1_rx, r1_ry, r1_wx, r1_dy;
    logic                 r1_cond;
    logic [TOL_W-1:0]     r1_tol;

    always_ff @(posedge i_clk) begin
        r1_ex   <= w_ex;
        r1_ey   <= w_ey;
        r1_qx   <= w_qx;
        r1_qy   <= w_qy;
        r1_rx   <= w_rx;
        r1_ry   <= w_ry;
        r1_wx   <= w_wx;
        r1_dy   <= w_dy;
        r1_cond <= w_cond;
        r1_tol  <= i_tol;
    end

    // Stage 2: products and the widened edge box.
    logic signed [BW-1:0] w_tp, w_tn, w_bqx, w_brx, w_bqy, w_bry;
    logic                 w_box;

    assign w_tp  = $signed({{(BW-TOL_W){1'b0}}, r1_tol});
    assign w_tn  = -w_tp;
    assign w_bqx = $signed({{(BW-DW){r1_qx[DW-1]}}, r1_qx});
    assign w_brx = $signed({{(BW-DW){r1_rx[DW-1]}}, r1_rx});
    assign w_bqy = $signed({{(BW-DW){r1_qy[DW-1]}}, r1_qy});
    assign w_bry = $signed({{(BW-DW){r1_ry[DW-1]}}, r1_ry});
    assign w_box = ((w_bqx >= w_tn) || (w_brx >= w_tn)) &&
                   ((w_bqx <= w_tp) || (w_brx <= w_tp)) &&
                   ((w_bqy >= w_tn) || (w_bry >= w_tn)) &&
                   ((w_bqy <= w_tp) || (w_bry <= w_tp));

    logic signed [PW-1:0] r2_pe, r2_pf, r2_pg, r2_ph;
    logic                 r2_box, r2_cond, r2_dy_pos;
    logic [TOL_W-1:0]     r2_tol;

    always_ff @(posedge i_clk) begin
        r2_pe     <= r1_ex * r1_qy;
        r2_pf     <= r1_ey * r1_qx;
        r2_pg     <= r1_qx * r1_dy;
        r2_ph     <= r1_wx * r1_qy;
        r2_box    <= w_box;
        r2_cond   <= r1_cond;
        r2_dy_pos <= r1_dy > 0;
        r2_tol    <= r1_tol;
    end

    // Stage 3: exact cross product differences.
    logic signed [SW-1:0] r3_d1, r3_d2;
    logic                 r3_box, r3_cond, r3_dy_pos;
    logic [TOL_W-1:0]     r3_tol;

    always_ff @(posedge i_clk) begin
        r3_d1     <= $signed({r2_pe[PW-1], r2_pe}) - $signed({r2_pf[PW-1], r2_pf});
        r3_d2     <= $signed({r2_pg[PW-1], r2_pg}) - $signed({r2_ph[PW-1], r2_ph});
        r3_box    <= r2_box;
        r3_cond   <= r2_cond;
        r3_dy_pos <= r2_dy_pos;
        r3_tol    <= r2_tol;
    end

    // Stage 4: decisions.
    logic signed [FW-1:0] w_ftp, w_fd1;
    logic                 w_on_edge, w_hit;

    assign w_ftp     = $signed({{(FW-TOL_W){1'b0}}, r3_tol});
    assign w_fd1     = $signed({{(FW-SW){r3_d1[SW-1]}}, r3_d1});
    assign w_on_edge = r3_box && (w_fd1 <= w_ftp) && (w_fd1 >= -w_ftp);
    assign w_hit     = r3_cond && (r3_dy_pos ? (r3_d2 < 0) : (r3_d2 > 0));

    logic r4_on_edge, r4_hit;

    always_ff @(posedge i_clk) begin
        r4_on_edge <= w_on_edge;
        r4_hit     <= w_hit;
    end

    t_tag r_tag [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < 4; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_res.valid   = r_tag[3].valid;
    assign o_res.last    = r_tag[3].last;
    assign o_res.on_edge = r4_on_edge;
    assign o_res.hit     = r4_hit;

endmodule

### verif/point_in_polygon_test_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// point_in_polygon_test_tb
// Self-checking testbench for the point-in-polygon test block.
//
// Requests are driven on the input stream and the query verdicts are taken
// from the output stream. Each accepted clear or append updates a behavioural
// copy of the ring, and a query's expected verdict comes from the directed
// table or from that copy. Results are compared field by field, in order.
// A short directed table covers empty and short rings, the unused action, a
// small square and a square spanning the whole coordinate range. It is
// followed by random ring sessions: closed rings with queries on vertices,
// edges, grid points and horizontal rays through vertices, plus broken rings
// and noise. The edge tolerance is changed between phases, including both
// extremes; handshakes stall at random in two patterns and not in a third.
// ============================================================================
module point_in_polygon_test_tb;
    import pip_pkg::*;

    localparam int     RING_CAPACITY  = 64;
    localparam int     COORD_BITS     = 32;
    localparam int     RESET_CYCLES   = 10;
    localparam int     SETTLE_CYCLES  = 100;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     PHASE_REQUESTS = 280;
    localparam int     PHASES         = 6;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_EDGE_TOL = {REG_EDGE_TOL, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    localparam longint COORD_MAX      = 64'sd2147483647;
    localparam longint COORD_MIN      = -COORD_MAX - 1;

    typedef struct packed {
        logic ring_overflow;
        logic ring_too_short;
        logic on_boundary;
        logic inside_res;
    } t_verdict;

    localparam t_verdict SHORT_RING   = 4'b0100;
    localparam t_verdict INSIDE_AREA  = 4'b0001;
    localparam t_verdict ON_EDGE      = 4'b0011;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] x;
        logic [31:0] y;
        logic        typed;
        t_verdict    want;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    longint   ring_vx [RING_CAPACITY];
    longint   ring_vy [RING_CAPACITY];
    int       ring_count;
    logic     ring_dropped;
    longint   edge_tol;
    t_verdict pending_verdicts [$];
    t_dir_row directed_rows [$];
    longint   session_vx [$];
    longint   session_vy [$];

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int hold_left;
    int idle_cycles = 0;
    int fails = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int inside_seen = 0;
    int boundary_seen = 0;
    int short_seen = 0;
    int dropped_seen = 0;
    int tol_settings = 0;

    point_in_polygon_test #(
        .MAX_RING_POINTS(RING_CAPACITY),
        .COORD_WIDTH    (COORD_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int sign_of(longint d);
        return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    function automatic bit [63:0] magnitude(longint d);
        return (d < 0) ? -d : d;
    endfunction

    function automatic int compare_products(longint a1, longint b1, longint a2, longint b2);
        int        s1;
        int        s2;
        bit [63:0] m1;
        bit [63:0] m2;
        s1 = sign_of(a1) * sign_of(b1);
        s2 = sign_of(a2) * sign_of(b2);
        m1 = magnitude(a1) * magnitude(b1);
        m2 = magnitude(a2) * magnitude(b2);
        if (s1 != s2)
            return (s1 < s2) ? -1 : 1;
        if (s1 == 0 || m1 == m2)
            return 0;
        if (s1 > 0)
            return (m1 < m2) ? -1 : 1;
        return (m1 < m2) ? 1 : -1;
    endfunction

    function automatic bit cross_within_tol(longint a1, longint b1, longint a2, longint b2,
                                            bit [63:0] tol);
        int        s1;
        int        s2;
        bit [63:0] m1;
        bit [63:0] m2;
        s1 = sign_of(a1) * sign_of(b1);
        s2 = sign_of(a2) * sign_of(b2);
        m1 = magnitude(a1) * magnitude(b1);
        m2 = magnitude(a2) * magnitude(b2);
        if (s1 * s2 >= 0)
            return ((m1 > m2) ? m1 - m2 : m2 - m1) <= tol;
        return (m1 <= tol) && (m2 <= tol - m1);
    endfunction

    function automatic t_verdict predict_verdict(longint px, longint py);
        t_verdict v;
        bit       odd;
        int       j;
        int       c;
        longint   ax, ay, bx, by, cx, cy, qx, qy, dy;
        v = '0;
        odd = 1'b0;
        v.ring_overflow = ring_dropped;
        if (ring_count < MIN_RING_POINTS) begin
            v.ring_too_short = 1'b1;
            return v;
        end
        for (int i = 0; (i + 1 < ring_count) && !v.on_boundary; i++) begin
            j = (i == 0) ? ring_count - CLOSE_BACK : i - 1;
            ax = ring_vx[i];
            ay = ring_vy[i];
            bx = ring_vx[i + 1];
            by = ring_vy[i + 1];
            qx = px - ax;
            qy = py - ay;
            if (cross_within_tol(bx - ax, qy, by - ay, qx, edge_tol)
                    && px >= ((ax < bx) ? ax : bx) - edge_tol
                    && px <= ((ax > bx) ? ax : bx) + edge_tol
                    && py >= ((ay < by) ? ay : by) - edge_tol
                    && py <= ((ay > by) ? ay : by) + edge_tol) begin
                v.on_boundary = 1'b1;
            end else begin
                cx = ring_vx[j];
                cy = ring_vy[j];
                if ((ay > py) != (cy > py)) begin
                    dy = cy - ay;
                    c = compare_products(qx, dy, cx - ax, qy);
                    if ((dy > 0) ? (c < 0) : (c > 0))
                        odd = ~odd;
                end
            end
        end
        v.inside_res = v.on_boundary | odd;
        return v;
    endfunction

    function automatic void track_request(logic [1:0] act, logic [31:0] x, logic [31:0] y,
                                          bit typed, t_verdict want);
        longint   px;
        longint   py;
        t_verdict v;
        px = $signed(x);
        py = $signed(y);
        case (act)
            ACT_CLEAR: begin
                ring_count = 0;
                ring_dropped = 1'b0;
            end
            ACT_APPEND: begin
                if (ring_count < RING_CAPACITY) begin
                    ring_vx[ring_count] = px;
                    ring_vy[ring_count] = py;
                    ring_count++;
                end else begin
                    ring_dropped = 1'b1;
                end
            end
            ACT_QUERY: begin
                v = typed ? want : predict_verdict(px, py);
                pending_verdicts.insert(pending_verdicts.size(), v);
            end
            default: ;
        endcase
    endfunction

    function automatic longint clamp_coord(longint v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic longint rand_span(longint r);
        bit [63:0] u;
        bit [63:0] m;
        u = {$urandom, $urandom};
        m = 2 * r + 1;
        return longint'(u % m) - r;
    endfunction

    function automatic longint snap(longint v, longint step);
        return (step <= 1) ? v : (v / step) * step;
    endfunction

    function automatic void add_row(logic [1:0] act, longint x, longint y, bit typed,
                                    t_verdict want);
        t_dir_row r;
        r.act = act;
        r.x = 32'(x);
        r.y = 32'(y);
        r.typed = typed;
        r.want = want;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    task automatic send_request(logic [1:0] act, longint x, longint y, bit typed,
                                t_verdict want);
        logic [31:0] cx;
        logic [31:0] cy;
        cx = 32'(clamp_coord(x));
        cy = 32'(clamp_coord(y));
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata = '0;
        s_axis_tdata[ACT_W-1:0] = act;
        s_axis_tdata[X_LSB +: COORD_IN_W] = cx;
        s_axis_tdata[Y_LSB +: COORD_IN_W] = cy;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        track_request(act, cx, cy, typed, want);
        if (act != ACT_UNUSED)
            requests_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic noise_request();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            send_request(ACT_UNUSED, $signed($urandom), $signed($urandom), 1'b0, '0);
        else if (roll < 25)
            send_request(ACT_QUERY, $signed($urandom), $signed($urandom), 1'b0, '0);
    endtask

    task automatic pick_query(longint ox, longint oy, longint span, longint step,
                              output longint qx, output longint qy);
        int     mode;
        int     idx;
        int     nxt;
        longint wob;
        wob = edge_tol + 2;
        mode = $urandom_range(5);
        idx = 0;
        nxt = 0;
        if (session_vx.size() == 0 && mode >= 2 && mode != 4)
            mode = 1;
        if (session_vx.size() > 0) begin
            idx = $urandom_range(session_vx.size() - 1);
            nxt = (idx + 1) % session_vx.size();
        end
        case (mode)
            0: begin
                qx = ox + rand_span(span + span / 4);
                qy = oy + rand_span(span + span / 4);
            end
            1: begin
                qx = ox + snap(rand_span(span), step);
                qy = oy + snap(rand_span(span), step);
            end
            2: begin
                qx = session_vx[idx] + rand_span(wob);
                qy = session_vy[idx] + rand_span(wob);
            end
            3: begin
                qx = (session_vx[idx] + session_vx[nxt]) / 2 + rand_span(wob);
                qy = (session_vy[idx] + session_vy[nxt]) / 2 + rand_span(wob);
            end
            4: begin
                qx = $signed($urandom);
                qy = $signed($urandom);
            end
            default: begin
                qx = ox + rand_span(span + span / 4);
                qy = session_vy[idx];
            end
        endcase
    endtask

    task automatic ring_session(int force_pts, int force_queries);
        int     n_pts;
        int     n_q;
        int     k;
        bit     tidy;
        bit     do_clear;
        bit     closed;
        longint span;
        longint step;
        longint ox;
        longint oy;
        longint qx;
        longint qy;
        tidy = (force_pts >= 0) || ($urandom_range(99) < 80);
        do_clear = tidy || $urandom_range(1);
        closed = tidy || $urandom_range(1);
        case ($urandom_range(3))
            0: span = 16;
            1: span = 1024;
            2: span = 1 << 20;
            default: span = COORD_MAX;
        endcase
        step = ($urandom_range(2) == 0) ? 1 : span / $urandom_range(2, 8);
        ox = rand_span(COORD_MAX - span);
        oy = rand_span(COORD_MAX - span);
        if (force_pts >= 0) begin
            n_pts = force_pts;
        end else begin
            k = $urandom_range(99);
            if (k < 8)
                n_pts = $urandom_range(2);
            else if (k < 80)
                n_pts = $urandom_range(3, 10);
            else if (k < 94)
                n_pts = $urandom_range(11, 40);
            else
                n_pts = $urandom_range(60, 70);
        end
        n_q = (force_queries >= 0) ? force_queries : $urandom_range(2, 10);
        session_vx.delete();
        session_vy.delete();
        if (do_clear)
            send_request(ACT_CLEAR, rand_span(COORD_MAX), rand_span(COORD_MAX), 1'b0, '0);
        for (k = 0; k < n_pts; k++) begin
            session_vx.insert(session_vx.size(), clamp_coord(ox + snap(rand_span(span), step)));
            session_vy.insert(session_vy.size(), clamp_coord(oy + snap(rand_span(span), step)));
            send_request(ACT_APPEND, session_vx[k], session_vy[k], 1'b0, '0);
            if (!tidy)
                noise_request();
        end
        if (closed && n_pts > 0)
            send_request(ACT_APPEND, session_vx[0], session_vy[0], 1'b0, '0);
        for (k = 0; k < n_q; k++) begin
            pick_query(ox, oy, span, step, qx, qy);
            send_request(ACT_QUERY, qx, qy, 1'b0, '0);
            if (!tidy)
                noise_request();
        end
    endtask

    task automatic settle();
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_read(logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] readback;
        word = $urandom;
        word[TOL_W-1:0] = value;
        apb_write(ADDR_EDGE_TOL, word);
        edge_tol = value;
        tol_settings++;
        apb_read(ADDR_EDGE_TOL, readback);
        if (readback !== CFG_DATA_W'(value)) begin
            $error("edge_tolerance: expected %0d, got %0d", value, readback);
            fails++;
        end
    endtask

    task automatic check_field(string name, logic want, logic got);
        if (got !== want) begin
            $error("%s: expected %b, got %b", name, want, got);
            fails++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : verdict_check
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            results_seen++;
            inside_seen += got.inside_res;
            boundary_seen += got.on_boundary;
            short_seen += got.ring_too_short;
            dropped_seen += got.ring_overflow;
            if (pending_verdicts.size() == 0) begin
                $error("Verdict %b arrived with no query outstanding.", got);
                fails++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("inside_res", want.inside_res, got.inside_res);
                check_field("on_boundary", want.on_boundary, got.on_boundary);
                check_field("ring_too_short", want.ring_too_short, got.ring_too_short);
                check_field("ring_overflow", want.ring_overflow, got.ring_overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int  start;
        bit  first;
        bit  paused;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        hold_left = 0;
        ring_count = 0;
        ring_dropped = 1'b0;
        edge_tol = 0;
        tx_idle_pct = 19;
        rx_idle_pct = 51;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(ACT_QUERY, 0, 0, 1'b1, SHORT_RING);
        add_row(ACT_UNUSED, -1, -1, 1'b0, '0);
        add_row(ACT_APPEND, 0, 0, 1'b0, '0);
        add_row(ACT_APPEND, 100, 0, 1'b0, '0);
        add_row(ACT_QUERY, 50, 50, 1'b1, SHORT_RING);
        add_row(ACT_APPEND, 100, 100, 1'b0, '0);
        add_row(ACT_APPEND, 0, 100, 1'b0, '0);
        add_row(ACT_APPEND, 0, 0, 1'b0, '0);
        add_row(ACT_QUERY, 50, 50, 1'b0, '0);
        add_row(ACT_QUERY, 100, 50, 1'b0, '0);
        add_row(ACT_QUERY, 0, 0, 1'b0, '0);
        add_row(ACT_QUERY, 150, 50, 1'b0, '0);
        add_row(ACT_QUERY, -1, 50, 1'b0, '0);
        add_row(ACT_QUERY, 50, 100, 1'b0, '0);
        add_row(ACT_CLEAR, COORD_MAX, COORD_MIN, 1'b0, '0);
        add_row(ACT_QUERY, 0, 0, 1'b1, SHORT_RING);
        add_row(ACT_APPEND, COORD_MIN, COORD_MIN, 1'b0, '0);
        add_row(ACT_APPEND, COORD_MAX, COORD_MIN, 1'b0, '0);
        add_row(ACT_APPEND, COORD_MAX, COORD_MAX, 1'b0, '0);
        add_row(ACT_APPEND, COORD_MIN, COORD_MAX, 1'b0, '0);
        add_row(ACT_APPEND, COORD_MIN, COORD_MIN, 1'b0, '0);
        add_row(ACT_QUERY, 0, 0, 1'b1, INSIDE_AREA);
        add_row(ACT_QUERY, COORD_MAX, 0, 1'b1, ON_EDGE);
        add_row(ACT_QUERY, COORD_MIN, COORD_MAX, 1'b1, ON_EDGE);
        add_row(ACT_UNUSED, COORD_MAX, COORD_MAX, 1'b0, '0);
        foreach (directed_rows[r])
            send_request(directed_rows[r].act, $signed(directed_rows[r].x),
                         $signed(directed_rows[r].y), directed_rows[r].typed,
                         directed_rows[r].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            tx_idle_pct = (ph < 2) ? 19 : ((ph < 4) ? 51 : 0);
            rx_idle_pct = (ph < 2) ? 51 : ((ph < 4) ? 19 : 0);
            if (ph == 1)
                apb_write(ADDR_UNMAPPED, $urandom);
            case (ph)
                0: set_tolerance(16'hFFFF);
                1: set_tolerance('0);
                2: set_tolerance($urandom_range(1, 16));
                3: set_tolerance($urandom_range(16'hFFFF));
                4: set_tolerance(1);
                default: set_tolerance($urandom_range(255));
            endcase
            start = requests_sent;
            first = 1'b1;
            paused = 1'b0;
            while (requests_sent - start < PHASE_REQUESTS) begin
                if (first && ph == 0) begin
                    ring_session(RING_CAPACITY + 2, 4);
                end else if (first && ph == 2) begin
                    hold_req = 1'b1;
                    ring_session(4, 12);
                end else begin
                    if (ph == 4 && !paused && requests_sent - start > PHASE_REQUESTS / 2) begin
                        settle();
                        paused = 1'b1;
                    end
                    ring_session(-1, -1);
                end
                first = 1'b0;
            end
        end

        settle();
        $display("Covered %0d requests and %0d verdicts: %0d inside, %0d on an edge.",
                 requests_sent, results_seen, inside_seen, boundary_seen);
        $display("Short-ring verdicts %0d, dropped-vertex verdicts %0d, tolerance settings %0d.",
                 short_seen, dropped_seen, tol_settings);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
